@@ rtl/sas_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI converter scan sequencer package
// Shared constants, codes and beat types for the scan sequencer.
// ----------------------------------------------------------------------------
package sas_pkg;

    localparam int TableDepth = 8;
    localparam int ChanW      = $clog2(TableDepth);
    localparam int CountW     = 4;
    localparam int FuncW      = 2;
    localparam int ByteW      = 8;
    localparam int SelW       = 4;
    localparam int ResultW    = 10;
    localparam int UpperW     = ResultW - ByteW;
    localparam int PhaseW     = 2;

    localparam logic [FuncW-1:0] FUNC_START = 2'd0;
    localparam logic [FuncW-1:0] FUNC_BYTE  = 2'd1;
    localparam logic [FuncW-1:0] FUNC_READ  = 2'd2;

    localparam logic [PhaseW-1:0] PH_IDLE  = 2'd0;
    localparam logic [PhaseW-1:0] PH_START = 2'd1;
    localparam logic [PhaseW-1:0] PH_CONF  = 2'd2;
    localparam logic [PhaseW-1:0] PH_READ  = 2'd3;

    localparam logic [ByteW-1:0]  BYTE_START     = 8'h01;
    localparam logic [ByteW-1:0]  BYTE_CONF_BASE = 8'h80;
    localparam logic [ByteW-1:0]  BYTE_DUMMY     = 8'h00;
    localparam logic [CountW-1:0] COUNT_RESET    = 4'd8;

    typedef struct packed {
        logic [FuncW-1:0] func;
        logic [ByteW-1:0] rx_byte;
        logic [SelW-1:0]  channel;
    } t_item;

    typedef struct packed {
        logic               send_valid;
        logic [ByteW-1:0]   send_byte;
        logic               select_active;
        logic [ResultW-1:0] read_value;
        logic               busy_res;
        logic               scan_done;
    } t_result;

endpackage

@@ rtl/sas_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scan sequencer engine
// Holds the exchange state and result table and computes one result per beat.
// ----------------------------------------------------------------------------
module sas_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  sas_pkg::t_item             i_item,
    input  logic [sas_pkg::CountW-1:0] i_scan_count,
    output sas_pkg::t_result           o_result
);

    logic [sas_pkg::PhaseW-1:0]  r_phase, n_phase;
    logic [sas_pkg::ChanW-1:0]   r_scan_channel, n_scan_channel;
    logic [sas_pkg::UpperW-1:0]  r_upper_bits, n_upper_bits;
    logic                        r_select, n_select;
    logic [sas_pkg::ResultW-1:0] r_table [sas_pkg::TableDepth];

    logic                        table_we;
    logic [sas_pkg::ResultW-1:0] table_wdata;
    logic [sas_pkg::CountW-1:0]  eff_count;
    logic [sas_pkg::CountW-1:0]  next_idx;
    sas_pkg::t_result            res;

    always_comb begin
        if (i_scan_count == '0) begin
            eff_count = sas_pkg::CountW'(1);
        end else if (i_scan_count > sas_pkg::CountW'(sas_pkg::TableDepth)) begin
            eff_count = sas_pkg::CountW'(sas_pkg::TableDepth);
        end else begin
            eff_count = i_scan_count;
        end
        next_idx = sas_pkg::CountW'(r_scan_channel) + sas_pkg::CountW'(1);
    end

    always_comb begin
        n_phase        = r_phase;
        n_scan_channel = r_scan_channel;
        n_upper_bits   = r_upper_bits;
        n_select       = r_select;
        table_we       = 1'b0;
        table_wdata    = {r_upper_bits, i_item.rx_byte};
        res            = '0;
        case (i_item.func)
            sas_pkg::FUNC_START: begin
                if (r_phase == sas_pkg::PH_IDLE) begin
                    n_phase        = sas_pkg::PH_START;
                    n_select       = 1'b1;
                    res.send_valid = 1'b1;
                    res.send_byte  = sas_pkg::BYTE_START;
                end
            end
            sas_pkg::FUNC_BYTE: begin
                unique case (r_phase)
                    sas_pkg::PH_START: begin
                        res.send_valid = 1'b1;
                        res.send_byte  = sas_pkg::BYTE_CONF_BASE
                                         | (sas_pkg::ByteW'(r_scan_channel) << 4);
                        n_phase        = sas_pkg::PH_CONF;
                    end
                    sas_pkg::PH_CONF: begin
                        n_upper_bits   = i_item.rx_byte[sas_pkg::UpperW-1:0];
                        res.send_valid = 1'b1;
                        res.send_byte  = sas_pkg::BYTE_DUMMY;
                        n_phase        = sas_pkg::PH_READ;
                    end
                    sas_pkg::PH_READ: begin
                        table_we = 1'b1;
                        n_select = 1'b0;
                        if (next_idx >= eff_count) begin
                            n_phase        = sas_pkg::PH_IDLE;
                            n_scan_channel = '0;
                            res.scan_done  = 1'b1;
                        end else begin
                            n_scan_channel = next_idx[sas_pkg::ChanW-1:0];
                            n_phase        = sas_pkg::PH_START;
                            n_select       = 1'b1;
                            res.send_valid = 1'b1;
                            res.send_byte  = sas_pkg::BYTE_START;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            sas_pkg::FUNC_READ: begin
                if (i_item.channel < sas_pkg::SelW'(sas_pkg::TableDepth)) begin
                    res.read_value = r_table[i_item.channel[sas_pkg::ChanW-1:0]];
                end
            end
            default: begin
            end
        endcase
        res.select_active = n_select;
        res.busy_res      = (n_phase != sas_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= sas_pkg::PH_IDLE;
            r_scan_channel <= '0;
            r_upper_bits   <= '0;
            r_select       <= 1'b0;
            for (int k = 0; k < sas_pkg::TableDepth; k++) begin
                r_table[k] <= '0;
            end
        end else if (i_valid) begin
            r_phase        <= n_phase;
            r_scan_channel <= n_scan_channel;
            r_upper_bits   <= n_upper_bits;
            r_select       <= n_select;
            if (table_we) begin
                r_table[r_scan_channel] <= table_wdata;
            end
        end
    end

    assign o_result = res;

endmodule

@@ rtl/spi_adc_scan_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI converter scan sequencer
// Steps an external 10-bit converter through a channel scan, one event a beat.
// ----------------------------------------------------------------------------
// Every input beat (start, byte finished, or read) yields exactly one output
// beat. The block takes one beat per clock cycle while the output side is not
// stalled; a beat passes an input register and the result register before its
// result is offered. The scan length register should be written only while no
// beat is in flight.
module spi_adc_scan_sequencer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [sas_pkg::CountW-1:0] i_cfg_wr_data,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // Fields from bit 0: rx_byte[7:0], channel[11:8], zero fill.
    input  logic [15:0]                i_s_tdata,
    // Fields from bit 0: func[1:0].
    input  logic [sas_pkg::FuncW-1:0]  i_s_tuser,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // Fields from bit 0: send_valid[0], send_byte[8:1], select_active[9],
    // read_value[19:10], busy_res[20], zero fill.
    output logic [23:0]                o_m_tdata,
    // Carries scan_done.
    output logic                       o_m_tlast
);

    logic [sas_pkg::CountW-1:0] r_scan_count;
    logic                       r_in_valid;
    sas_pkg::t_item             r_in;
    logic                       r_out_valid;
    sas_pkg::t_result           r_out;
    sas_pkg::t_result           result;
    logic                       advance;

    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_count <= sas_pkg::COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_scan_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in.func    <= i_s_tuser;
            r_in.rx_byte <= i_s_tdata[7:0];
            r_in.channel <= i_s_tdata[11:8];
        end
    end

    sas_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (advance),
        .i_item       (r_in),
        .i_scan_count (r_scan_count),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.busy_res, r_out.read_value, r_out.select_active,
                         r_out.send_byte, r_out.send_valid};
    assign o_m_tlast  = r_out.scan_done;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.scan_done) |-> !r_out.busy_res)
        else $error("scan done reported while still busy");

    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.select_active == r_out.busy_res))
        else $error("chip select level disagrees with busy status");

    a_send_selected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.send_valid) |-> r_out.select_active)
        else $error("byte sent with chip select released");

    a_read_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.read_value != '0)) |-> !r_out.send_valid)
        else $error("read result and byte send in the same beat");

endmodule
